FILE: hdl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared types and codes of the record list engine
// Request and result payloads, record layout, command and status codes.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_INSERT_AT = 3'd1;
  localparam logic [2:0] CMD_INS_AFTER = 3'd2;
  localparam logic [2:0] CMD_REMOVE    = 3'd3;
  localparam logic [2:0] CMD_UPDATE    = 3'd4;
  localparam logic [2:0] CMD_RANGE     = 3'd5;
  localparam logic [2:0] CMD_SORT      = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // register byte addresses
  localparam logic [2:0] ADDR_PC_LOW  = 3'd0;
  localparam logic [2:0] ADDR_PC_HIGH = 3'd4;

  localparam logic [19:0] PC_LOW_RST  = 20'd1500;
  localparam logic [19:0] PC_HIGH_RST = 20'd2500;

  typedef struct packed {
    logic [15:0] id;
    logic [63:0] name;
    logic [15:0] population;
    logic [63:0] language;
    logic [19:0] gdp;
    logic [19:0] per_capita;
  } rec_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  position;
    logic [63:0] match_name;
    logic [15:0] match_id;
    logic [15:0] new_id;
    logic [63:0] new_name;
    logic [15:0] new_population;
    logic [63:0] new_language;
    logic [19:0] new_gdp;
    logic [19:0] new_per_capita;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [15:0] out_id;
    logic [63:0] out_name;
    logic [15:0] out_population;
    logic [63:0] out_language;
    logic [19:0] out_gdp;
    logic [19:0] out_per_capita;
    logic        last;
  } rsp_t;

  // per-cycle control from the sequencer to every cell
  typedef struct packed {
    logic shift_up;    // take left neighbor's record
    logic shift_down;  // take right neighbor's record
    logic write_new;   // write new record at the target cell
    logic upd_match;   // rewrite cells whose id matches
    logic rotate;      // ring rotation toward index 0
  } cell_ctl_t;

endpackage

FILE: hdl/record_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_list_engine_top: fixed-capacity ordered record list
// A row of MAX_ENTRIES cells holds the list; a sequencer drives shifts,
// rotations and the exchange sort one compare per cycle.
// ----------------------------------------------------------------------------
// Append, insert-at and early errors answer in the cycle after acceptance;
//   insert-after, remove, update and range rotate the whole ring through
//   slot 0 and then give their final result.
// Sort: exchange-sort compares over the entries, an exit step, then the list.
// One request at a time: busy_o is high until the sequencer is idle, also
//   through a full sort. No result stall.
// Reset clears the count and the sequencer and sets the range bounds to their
//   defaults; slots are not cleared (only slots below the count are ever read).
module record_list_engine_top
  import rle_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (CW > 5) ? CW : 5;   // position compare width
  localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;  // rotate ring, compare slot 0
  localparam logic [3:0] S_INSERT = 4'd2;
  localparam logic [3:0] S_REMOVE = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;  // update / range walk
  localparam logic [3:0] S_SORT   = 4'd5;
  localparam logic [3:0] S_LIST   = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;  // final result from res_q

  // ---------------- configuration ----------------
  logic [19:0] pc_low_q, pc_high_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_low_q  <= PC_LOW_RST;
      pc_high_q <= PC_HIGH_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_PC_LOW) pc_low_q  <= pwdata[19:0];
      if (paddr == ADDR_PC_HIGH) pc_high_q <= pwdata[19:0];
    end
  end
  always_comb begin
    case (paddr)
      ADDR_PC_LOW:  prdata = {12'd0, pc_low_q};
      ADDR_PC_HIGH: prdata = {12'd0, pc_high_q};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------- state ----------------
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;     // general walk counter
  logic [CW-1:0] si_q, si_d;       // sort outer index
  logic [CW-1:0] sj_q, sj_d;       // sort inner index
  logic [CW-1:0] tgt_q, tgt_d;     // target slot for insert/remove
  logic          hit_q, hit_d;     // match seen; in scan, res_q holds a pending result
  req_t          req_q;
  rsp_t          res_q, res_d;
  rsp_t          rsp_d;
  logic          rsp_v_d;

  rec_t          new_rec;
  assign new_rec = '{id: req_q.new_id, name: req_q.new_name,
                     population: req_q.new_population, language: req_q.new_language,
                     gdp: req_q.new_gdp, per_capita: req_q.new_per_capita};

  // ---------------- cell row ----------------
  cell_ctl_t ctl;
  rec_t      recs [MAX_ENTRIES];
  logic      sort_wr;
  rec_t      swap_a, swap_b;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    rec_t left_in, right_in;
    if (g == 0) begin : g_l0
      assign left_in = recs[0];
    end else begin : g_ln
      assign left_in = recs[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_rl
      assign right_in = recs[0];
    end else begin : g_rn
      assign right_in = recs[g+1];
    end
    // during a sort swap both compared cells are targets and take each other
    rle_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .at_or_above_i (CW'(g) >= tgt_q),
      .is_target_i   (sort_wr ? (CW'(g) == si_q || CW'(g) == sj_q) : (CW'(g) == tgt_q)),
      .below_count_i (CW'(g) < count_q),
      .match_id_i    (req_q.match_id),
      .new_rec_i     (sort_wr ? ((CW'(g) == si_q) ? swap_b : swap_a) : new_rec),
      .left_i        (left_in),
      .right_i       (right_in),
      .rec_o         (recs[g])
    );
  end

  // sort compare: one pair per cycle
  assign swap_a = recs[si_q[IW-1:0]];
  assign swap_b = recs[sj_q[IW-1:0]];

  function automatic rsp_t mk(logic [2:0] st, logic [CW-1:0] idx, rec_t r, logic lst);
    rsp_t o;
    o.status = st; o.entry_index = 4'(idx); o.out_id = r.id; o.out_name = r.name;
    o.out_population = r.population; o.out_language = r.language;
    o.out_gdp = r.gdp; o.out_per_capita = r.per_capita; o.last = lst;
    return o;
  endfunction

  function automatic rsp_t mk_err(logic [2:0] st);
    return mk(st, '0, '0, 1'b1);
  endfunction

  // slot 0 during walks: the ring rotates so recs[0] is entry ptr
  rec_t head;
  assign head = recs[0];
  logic in_range;
  assign in_range = head.per_capita >= pc_low_q && head.per_capita <= pc_high_q;

  // updated image of the head entry (id kept)
  rec_t upd_rec;
  always_comb begin
    upd_rec = new_rec;
    upd_rec.id = head.id;
  end

  logic scan_hit;
  rec_t scan_rec;
  assign scan_hit = (ptr_q < count_q) &&
                    ((req_q.command == CMD_UPDATE) ? (head.id == req_q.match_id) : in_range);
  assign scan_rec = (req_q.command == CMD_UPDATE) ? upd_rec : head;

  logic accept;
  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q; count_d = count_q; ptr_d = ptr_q; si_d = si_q; sj_d = sj_q;
    tgt_d = tgt_q; hit_d = hit_q; res_d = res_q;
    rsp_v_d = 1'b0; rsp_d = '0;
    ctl = '0; sort_wr = 1'b0;
    case (state_q)
      S_IDLE: begin
        ptr_d = '0; hit_d = 1'b0; si_d = '0; sj_d = CW'(1);
        if (accept) begin
          case (req_i.command)
            CMD_APPEND: begin
              if (count_q == CAP) begin
                res_d = mk_err(ST_FULL); state_d = S_DONE;
              end else begin
                tgt_d = count_q; state_d = S_INSERT;
              end
            end
            CMD_INSERT_AT: begin
              if (count_q == CAP) begin
                res_d = mk_err(ST_FULL); state_d = S_DONE;
              end else if (PW'(req_i.position) > PW'(count_q)) begin
                res_d = mk_err(ST_BADPOS); state_d = S_DONE;
              end else begin
                tgt_d = CW'(req_i.position); state_d = S_INSERT;
              end
            end
            CMD_INS_AFTER, CMD_REMOVE: state_d = S_SEARCH;
            CMD_UPDATE: state_d = S_SCAN;
            CMD_RANGE: begin
              if (count_q == '0) begin
                res_d = mk_err(ST_EMPTY); state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_SORT: begin
              if (count_q == '0) begin
                res_d = mk_err(ST_EMPTY); state_d = S_DONE;
              end else begin
                state_d = S_SORT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // full-ring rotation over all MAX_ENTRIES slots, first name match wins
      S_SEARCH: begin
        ctl.rotate = 1'b1;
        if (ptr_q < count_q && !hit_q && head.name == req_q.match_name) begin
          hit_d = 1'b1; tgt_d = ptr_q;
          res_d = mk(ST_OK, ptr_q, head, 1'b1);
        end
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CAP - 1'b1) begin
          if (!hit_d) begin
            res_d = mk_err(ST_NOTFOUND); state_d = S_DONE;
          end else if (req_q.command == CMD_REMOVE) begin
            state_d = S_REMOVE;
          end else if (count_q == CAP) begin
            res_d = mk_err(ST_FULL); state_d = S_DONE;
          end else begin
            tgt_d = tgt_d + 1'b1; state_d = S_INSERT;
          end
        end
      end
      // results are held one hit back so the final one can carry last
      S_SCAN: begin
        ctl.rotate = 1'b1;
        if (scan_hit) begin
          if (hit_q) begin
            rsp_v_d = 1'b1; rsp_d = res_q;
          end
          hit_d = 1'b1;
          res_d = mk(ST_OK, ptr_q, scan_rec, 1'b0);
        end
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CAP - 1'b1) begin
          state_d = S_DONE;
          if (!hit_d) res_d = mk_err(ST_NOTFOUND);
        end
      end
      S_INSERT: begin
        ctl.shift_up = 1'b1;
        ctl.write_new = 1'b1;
        count_d = count_q + 1'b1;
        rsp_v_d = 1'b1;
        rsp_d = mk(ST_OK, tgt_q, new_rec, 1'b1);
        state_d = S_IDLE;
      end
      S_REMOVE: begin
        ctl.shift_down = 1'b1;
        count_d = count_q - 1'b1;
        rsp_v_d = 1'b1;
        rsp_d = res_q;
        state_d = S_IDLE;
      end
      S_SORT: begin
        if (si_q + 1'b1 >= count_q) begin
          ptr_d = '0; state_d = S_LIST;
        end else begin
          sort_wr = swap_a.gdp < swap_b.gdp;
          ctl.write_new = sort_wr;
          if (sj_q + 1'b1 >= count_q) begin
            si_d = si_q + 1'b1; sj_d = si_q + CW'(2);
          end else begin
            sj_d = sj_q + 1'b1;
          end
        end
      end
      S_LIST: begin
        ctl.rotate = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q < count_q) begin
          rsp_v_d = 1'b1;
          rsp_d = mk(ST_OK, ptr_q, head, ptr_q + 1'b1 == count_q);
        end
        if (ptr_q == CAP - 1'b1) state_d = S_IDLE;
      end
      S_DONE: begin
        // update writes all matching cells at once; ids do not change
        ctl.upd_match = (req_q.command == CMD_UPDATE);
        rsp_v_d = 1'b1;
        rsp_d = res_q;
        rsp_d.last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_v_d;
  assign rsp_o = rsp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; ptr_q <= '0; si_q <= '0; sj_q <= '0;
      tgt_q <= '0; hit_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ptr_q <= ptr_d; si_q <= si_d;
      sj_q <= sj_d; tgt_q <= tgt_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP) else $error("count above capacity");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |=> !rsp_valid_o) else $error("result after last");
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy_o) else $error("result while idle");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == S_INSERT || $past(state_q) == S_REMOVE)
    else $error("count moved outside insert/remove");
`endif

endmodule

FILE: hdl/rle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_cell: one list slot
// Holds one record; rotates or shifts to/from neighbors, takes a new record or an update.
// ----------------------------------------------------------------------------
module rle_cell
  import rle_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      at_or_above_i,  // index >= target position
  input  logic      is_target_i,
  input  logic      below_count_i,
  input  logic [15:0] match_id_i,
  input  rec_t      new_rec_i,
  input  rec_t      left_i,
  input  rec_t      right_i,
  output rec_t      rec_o
);

  rec_t rec_q, rec_d;
  logic upd_hit;

  assign upd_hit = below_count_i && (rec_q.id == match_id_i);

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.rotate) begin
      rec_d = right_i;
    end else if (ctl_i.write_new && is_target_i) begin
      rec_d = new_rec_i;
    end else if (ctl_i.shift_up && at_or_above_i) begin
      rec_d = left_i;
    end else if (ctl_i.shift_down && at_or_above_i) begin
      rec_d = right_i;
    end else if (ctl_i.upd_match && upd_hit) begin
      rec_d = new_rec_i;
      rec_d.id = rec_q.id;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
